FILE: src/i2cmbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types and constants: operation codes, one-hot phase codes, the
// register map of the configuration port and the engine state record.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned OpW = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitIdxW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] HalfPeriodReset = 16'd100;
  localparam logic [TickW-1:0] StretchLimitReset = 16'd1000;

  // Bit counter values with a meaning of their own.
  localparam logic [BitIdxW-1:0] BitsPerByte = 4'd8;
  localparam logic [BitIdxW-1:0] AckSlot = 4'd9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_PERIOD   = 2'd0,
    CFG_STRETCH_LIMIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [OpW-1:0] {
    OP_START   = 3'd0,
    OP_RESTART = 3'd1,
    OP_STOP    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [16:0] {
    PH_IDLE    = 17'h00001,
    PH_START_W = 17'h00002,
    PH_RS_W1   = 17'h00004,
    PH_RS_W2   = 17'h00008,
    PH_RS_W3   = 17'h00010,
    PH_SP_W    = 17'h00020,
    PH_RISE    = 17'h00040,
    PH_HOLD1   = 17'h00080,
    PH_HOLD2   = 17'h00100,
    PH_SP_END1 = 17'h00200,
    PH_SP_END2 = 17'h00400,
    PH_WR_BIT  = 17'h00800,
    PH_WR_GAP1 = 17'h01000,
    PH_WR_GAP2 = 17'h02000,
    PH_RD_PRE  = 17'h04000,
    PH_RD_LOW  = 17'h08000,
    PH_RD_ACKW = 17'h10000
  } phase_t;

  // One tick of bus inputs and command request.
  typedef struct packed {
    logic             cmd_valid;
    logic [OpW-1:0]   operation;
    logic [ByteW-1:0] tx_byte;
    logic             send_ack;
    logic             scl_in;
    logic             sda_in;
  } tick_in_t;

  typedef struct packed {
    phase_t             phase;
    logic [OpW-1:0]     current_op;
    logic [BitIdxW-1:0] bit_index;
    logic [ByteW-1:0]   shift_reg;
    logic [TickW-1:0]   delay_count;
    logic [TickW-1:0]   stretch_count;
    logic               scl_level;
    logic               sda_level;
    logic               ack_hold;
    logic               timeout_flag;
    logic               ack_request;
    logic [ByteW-1:0]   rx_last;
  } engine_state_t;

  localparam engine_state_t EngineReset = '{
    phase:         PH_IDLE,
    current_op:    '0,
    bit_index:     '0,
    shift_reg:     '0,
    delay_count:   '0,
    stretch_count: '0,
    scl_level:     1'b1,
    sda_level:     1'b1,
    ack_hold:      1'b1,
    timeout_flag:  1'b0,
    ack_request:   1'b0,
    rx_last:       '0
  };

endpackage

FILE: src/i2cmbe_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine tick logic
// Next-state logic of the bus timing sequencer for one clock tick.
// ----------------------------------------------------------------------------
module i2cmbe_step (
  input  i2cmbe_pkg::engine_state_t        cur,
  input  i2cmbe_pkg::tick_in_t             tick,
  input  logic [i2cmbe_pkg::TickW-1:0]     half_period,
  input  logic [i2cmbe_pkg::TickW-1:0]     stretch_limit,
  output i2cmbe_pkg::engine_state_t        nxt,
  output logic                             done
);
  import i2cmbe_pkg::*;

  logic [TickW-1:0] half_ticks;

  // A zero half period is treated as a half period of 1.
  assign half_ticks = (half_period == '0) ? {{(TickW-1){1'b0}}, 1'b1} : half_period;

  // Work done once SCL has been high for its full time (or the stretch
  // wait gave up).
  function automatic engine_state_t after_high(engine_state_t s, logic sda,
                                               logic [TickW-1:0] ht);
    engine_state_t r;
    logic [BitIdxW-1:0] bi_inc;
    r = s;
    bi_inc = s.bit_index + 1'b1;
    if (s.current_op == OP_STOP) begin
      r.sda_level = 1'b1;
      r.delay_count = ht;
      r.phase = PH_SP_END1;
    end else if (s.current_op == OP_WRITE) begin
      if (s.bit_index >= AckSlot) begin
        r.ack_hold = sda;
        r.scl_level = 1'b0;
        r.phase = PH_IDLE;
      end else begin
        r.bit_index = bi_inc;
        r.scl_level = 1'b0;
        r.delay_count = ht;
        if (bi_inc < BitsPerByte) begin
          r.sda_level = s.shift_reg[ByteW-1];
          r.shift_reg = {s.shift_reg[ByteW-2:0], 1'b0};
          r.phase = PH_WR_BIT;
        end else begin
          r.phase = PH_WR_GAP1;
        end
      end
    end else begin
      r.scl_level = 1'b0;
      if (s.bit_index >= AckSlot) begin
        r.rx_last = s.shift_reg;
        r.phase = PH_IDLE;
      end else begin
        r.shift_reg = {s.shift_reg[ByteW-2:0], sda};
        r.bit_index = bi_inc;
        r.delay_count = ht;
        r.phase = PH_RD_LOW;
      end
    end
    return r;
  endfunction

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_IDLE: begin
        if (tick.cmd_valid && (tick.operation <= OP_READ)) begin
          nxt.current_op = tick.operation;
          nxt.bit_index = '0;
          nxt.delay_count = half_ticks;
          case (tick.operation)
            OP_START: begin
              nxt.sda_level = 1'b0;
              nxt.phase = PH_START_W;
            end
            OP_RESTART: begin
              nxt.sda_level = 1'b1;
              nxt.scl_level = 1'b1;
              nxt.phase = PH_RS_W1;
            end
            OP_STOP: begin
              nxt.sda_level = 1'b0;
              nxt.phase = PH_SP_W;
            end
            OP_WRITE: begin
              nxt.scl_level = 1'b0;
              nxt.sda_level = tick.tx_byte[ByteW-1];
              nxt.shift_reg = {tick.tx_byte[ByteW-2:0], 1'b0};
              nxt.phase = PH_WR_BIT;
            end
            default: begin
              nxt.shift_reg = '0;
              nxt.ack_request = tick.send_ack;
              nxt.sda_level = 1'b1;
              nxt.phase = PH_RD_PRE;
            end
          endcase
        end
      end
      PH_RISE: begin
        if (tick.scl_in) begin
          nxt.delay_count = half_ticks;
          nxt.phase = PH_HOLD1;
        end else if (cur.stretch_count >= stretch_limit) begin
          nxt = after_high(cur, tick.sda_in, half_ticks);
          nxt.timeout_flag = 1'b1;
        end else begin
          nxt.stretch_count = cur.stretch_count + 1'b1;
        end
      end
      default: begin
        if (cur.delay_count > {{(TickW-1){1'b0}}, 1'b1}) begin
          nxt.delay_count = cur.delay_count - 1'b1;
        end else begin
          nxt.delay_count = '0;
          case (cur.phase)
            PH_START_W, PH_RS_W3: begin
              nxt.scl_level = 1'b0;
              nxt.phase = PH_IDLE;
            end
            PH_RS_W1: begin
              nxt.delay_count = half_ticks;
              nxt.phase = PH_RS_W2;
            end
            PH_RS_W2: begin
              nxt.sda_level = 1'b0;
              nxt.delay_count = half_ticks;
              nxt.phase = PH_RS_W3;
            end
            PH_SP_W, PH_WR_BIT, PH_RD_PRE: begin
              nxt.scl_level = 1'b1;
              nxt.stretch_count = '0;
              nxt.phase = PH_RISE;
            end
            PH_HOLD1: begin
              nxt.delay_count = half_ticks;
              nxt.phase = PH_HOLD2;
            end
            PH_HOLD2: begin
              nxt = after_high(cur, tick.sda_in, half_ticks);
            end
            PH_SP_END1: begin
              nxt.delay_count = half_ticks;
              nxt.phase = PH_SP_END2;
            end
            PH_SP_END2: begin
              nxt.phase = PH_IDLE;
            end
            PH_WR_GAP1: begin
              nxt.sda_level = 1'b1;
              nxt.delay_count = half_ticks;
              nxt.phase = PH_WR_GAP2;
            end
            PH_WR_GAP2, PH_RD_ACKW: begin
              nxt.bit_index = AckSlot;
              nxt.scl_level = 1'b1;
              nxt.stretch_count = '0;
              nxt.phase = PH_RISE;
            end
            PH_RD_LOW: begin
              if (cur.bit_index < BitsPerByte) begin
                nxt.scl_level = 1'b1;
                nxt.stretch_count = '0;
                nxt.phase = PH_RISE;
              end else begin
                if (cur.ack_request) begin
                  nxt.sda_level = 1'b0;
                end
                nxt.delay_count = half_ticks;
                nxt.phase = PH_RD_ACKW;
              end
            end
            default: begin
              nxt.phase = PH_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  // Every path into idle from a busy phase is a command completion.
  assign done = (cur.phase != PH_IDLE) && (nxt.phase == PH_IDLE);

endmodule

FILE: src/i2c_master_bit_engine_core.sv
// The result word for a tick is registered and appears in the cycle after the tick is accepted.
// Throughput: one tick word per cycle while the output is not stalled; the sequencer state register closes the loop.
// The output register frees in the cycle it is taken, so ticks stream without gaps.
// Reset (rst, synchronous) puts the bus sequencer idle with both lines released,
// and loads the half period with 100 and the stretch limit with 1000.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Open-drain I2C master advanced one clock tick per input word. Generates
// start, repeated start, stop, byte write with ack sampling and byte read
// with ack or nack, honoring clock stretching with a sticky timeout flag.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2cmbe_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [i2cmbe_pkg::TickW-1:0]      cfg_data,
  // Tick input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd_valid,
  input  logic [i2cmbe_pkg::OpW-1:0]        operation,
  input  logic [i2cmbe_pkg::ByteW-1:0]      tx_byte,
  input  logic                              send_ack,
  input  logic                              scl_in,
  input  logic                              sda_in,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              scl_release,
  output logic                              sda_release,
  output logic                              busy_res,
  output logic                              done_res,
  output logic                              ack_bit,
  output logic [i2cmbe_pkg::ByteW-1:0]      rx_byte,
  output logic                              stretch_timeout
);
  import i2cmbe_pkg::*;

  logic [TickW-1:0] half_period;
  logic [TickW-1:0] stretch_limit;
  engine_state_t    state;
  engine_state_t    state_next;
  tick_in_t         tick;
  logic             step_done;
  logic             in_accept;

  // Registers are always writable; software must only write them while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HalfPeriodReset;
      stretch_limit <= StretchLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HALF_PERIOD:   half_period <= cfg_data;
        CFG_STRETCH_LIMIT: stretch_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register is the only buffer: a new word may enter whenever the
  // register is empty or being emptied in this same cycle.
  assign in_stall = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign tick = '{
    cmd_valid: cmd_valid,
    operation: operation,
    tx_byte:   tx_byte,
    send_ack:  send_ack,
    scl_in:    scl_in,
    sda_in:    sda_in
  };

  // The whole tick is evaluated combinationally from the current sequencer
  // state; the state only advances on an accepted word.
  i2cmbe_step u_step (
    .cur           (state),
    .tick          (tick),
    .half_period   (half_period),
    .stretch_limit (stretch_limit),
    .nxt           (state_next),
    .done          (step_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EngineReset;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload reflects the state after this tick's update.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      scl_release <= state_next.scl_level;
      sda_release <= state_next.sda_level;
      busy_res <= (state_next.phase != PH_IDLE);
      done_res <= step_done;
      ack_bit <= state_next.ack_hold;
      rx_byte <= state_next.rx_last;
      stretch_timeout <= state_next.timeout_flag;
    end
  end

  // A completion word never reports the engine as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done reported while busy");

  // The stretch timeout flag is sticky until reset.
  a_timeout_sticky: assert property (@(posedge clk) disable iff (rst)
    state.timeout_flag |=> state.timeout_flag)
    else $error("stretch timeout flag cleared");

  // The bit counter never runs past the acknowledge slot.
  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    state.bit_index <= AckSlot)
    else $error("bit index out of range");

  // A completion can only come out of a busy phase.
  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    (in_accept && step_done) |-> (state.phase != PH_IDLE))
    else $error("completion from idle");

  // The sequencer state is frozen while no word is accepted.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(state))
    else $error("state changed without a tick");

endmodule
